>>> design/ice_pkg.sv
// package: ice level-1 cipher types, constants and table functions
`timescale 1ns / 1ps

package ice_pkg;

    // key bytes split into four 16-bit rotation words
    typedef logic [3:0][15:0] kb_t;

    // one round subkey: three 20-bit words
    typedef logic [2:0][19:0] sk_t;

    // seventh-power tables, one 256-entry byte table per s-box and row
    typedef logic [15:0][255:0][7:0] pow_tab_t;

    // control sequencer states
    typedef enum logic [1:0]
    {
        ST_INIT,
        ST_SCHED,
        ST_IDLE,
        ST_RUN
    } state_t;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_THIN = 1'b1;

    localparam int NUM_ROUNDS = 16;
    localparam int RND_W      = $clog2(NUM_ROUNDS);

    // p-box: destination bit for each source bit
    localparam logic [0:31][31:0] PBOX = '{
        32'h00000001, 32'h00000080, 32'h00000400, 32'h00002000,
        32'h00080000, 32'h00200000, 32'h01000000, 32'h40000000,
        32'h00000008, 32'h00000020, 32'h00000100, 32'h00004000,
        32'h00010000, 32'h00800000, 32'h04000000, 32'h20000000,
        32'h00000004, 32'h00000010, 32'h00000200, 32'h00008000,
        32'h00020000, 32'h00400000, 32'h08000000, 32'h10000000,
        32'h00000002, 32'h00000040, 32'h00000800, 32'h00001000,
        32'h00040000, 32'h00100000, 32'h02000000, 32'h80000000};

    // field polynomials per s-box and row
    localparam logic [0:3][0:3][8:0] SMOD = '{
        '{9'd333, 9'd313, 9'd505, 9'd369},
        '{9'd379, 9'd375, 9'd319, 9'd391},
        '{9'd361, 9'd445, 9'd451, 9'd397},
        '{9'd397, 9'd425, 9'd395, 9'd505}};

    // input xor constants per s-box and row
    localparam logic [0:3][0:3][7:0] SXOR = '{
        '{8'h83, 8'h85, 8'h9B, 8'hCD},
        '{8'hCC, 8'hA7, 8'hAD, 8'h41},
        '{8'h4B, 8'h2E, 8'hD4, 8'h33},
        '{8'hEA, 8'hCB, 8'h2E, 8'h04}};

    // key rotation start word per subkey
    localparam logic [0:15][1:0] ROT_TAB = '{
        2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd1, 2'd3, 2'd0,
        2'd1, 2'd3, 2'd2, 2'd0, 2'd3, 2'd1, 2'd0, 2'd2};

    // gf(2^8) multiply modulo m
    function automatic logic [7:0] gf_mul(input logic [7:0] a_in, input logic [7:0] b,
                                          input logic [8:0] m);
        logic [8:0] a;
        logic [7:0] r;
        a = {1'b0, a_in};
        r = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                r = r ^ a[7:0];
            a = {a[7:0], 1'b0};
            if (a[8])
                a = a ^ m;
        end
        return r;
    endfunction

    // seventh power in gf(2^8)
    function automatic logic [7:0] gf_pow7(input logic [7:0] b, input logic [8:0] m);
        logic [7:0] x;
        x = gf_mul(b, b, m);
        x = gf_mul(b, x, m);
        x = gf_mul(x, x, m);
        return gf_mul(b, x, m);
    endfunction

    // seventh-power tables, worked out at elaboration
    function automatic pow_tab_t build_pow_tab();
        pow_tab_t t;
        for (int n = 0; n < 4; n++)
        begin
            for (int row = 0; row < 4; row++)
            begin
                for (int col = 0; col < 256; col++)
                begin
                    t[n*4+row][col] = gf_pow7(8'(col) ^ SXOR[n][row], SMOD[n][row]);
                end
            end
        end
        return t;
    endfunction

    localparam pow_tab_t POW_TAB = build_pow_tab();

    // p-box bit scatter
    function automatic logic [31:0] permute(input logic [31:0] x);
        logic [31:0] r;
        r = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (x[i])
                r = r | PBOX[i];
        end
        return r;
    endfunction

    // s-box n at a 10-bit index
    function automatic logic [31:0] sbox(input logic [1:0] n, input logic [9:0] idx);
        logic [1:0]  row;
        logic [7:0]  v;
        row = {idx[9], idx[0]};
        v   = POW_TAB[{n, row}][idx[8:1]];
        return permute(32'(v) << {~n, 3'b000});
    endfunction

    // ice round function
    function automatic logic [31:0] round_fn(input logic [31:0] p, input sk_t sk);
        logic [19:0] tl;
        logic [19:0] tr;
        logic [19:0] al;
        logic [19:0] ar;
        tl = {p[1:0], p[31:24], p[25:16]};
        tr = {p[17:8], p[9:0]};
        al = sk[2] & (tl ^ tr);
        ar = al ^ tr ^ tl;
        al = al ^ sk[0];
        ar = ar ^ sk[1];
        return sbox(2'd0, al[19:10]) | sbox(2'd1, al[9:0]) |
               sbox(2'd2, ar[19:10]) | sbox(2'd3, ar[9:0]);
    endfunction

    // subkey words taken from the rotation words
    function automatic sk_t sched_words(input kb_t kb, input logic [1:0] rot);
        sk_t        w;
        logic [1:0] sel;
        w = '0;
        for (int m = 0; m < 3; m++)
        begin
            for (int t = 0; t < 5; t++)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    sel = rot + 2'(k);
                    w[m][19 - (t*4 + k)] = kb[sel][m + 3*t];
                end
            end
        end
        return w;
    endfunction

    // rotation words after one subkey: fifteen inverting right shifts
    function automatic kb_t kb_advance(input kb_t kb);
        kb_t r;
        for (int i = 0; i < 4; i++)
        begin
            r[i] = {~kb[i][14:0], kb[i][15]};
        end
        return r;
    endfunction

endpackage

>>> design/ice_block_cipher_top.sv
// ice level-1 cipher: one shared round unit, iterative key schedule builder
// rounds: one round per cycle; done strobes with the result after the last round
// a new block is taken only in idle, once the last block is done; busy holds off start meanwhile
// the run length follows from the mode's round count and the single round unit
// reset and every key or mode write rebuild the schedule, one subkey a cycle, with busy held
// meanwhile; results are strobed on done and cannot be stalled
`timescale 1ns / 1ps

module ice_block_cipher_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ice_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [63:0]                     cfg_data,
    input  logic                            start,
    output logic                            busy,
    input  logic                            kind,
    input  logic [63:0]                     in_block,
    output logic                            done,
    output logic [63:0]                     out_block
);

    ice_pkg::state_t                state_reg, state_next;
    logic [63:0]                    key_reg, key_next;
    logic                           thin_reg, thin_next;
    logic [ice_pkg::RND_W-1:0]      cnt_reg, cnt_next;
    ice_pkg::kb_t                   kb_reg, kb_next;
    logic [ice_pkg::RND_W-1:0]      rnd_reg, rnd_next;
    logic                           kind_reg, kind_next;
    logic [31:0]                    l_reg, l_next;
    logic [31:0]                    r_reg, r_next;
    logic                           done_reg, done_next;
    logic [63:0]                    out_reg, out_next;
    ice_pkg::sk_t                   sk_reg [ice_pkg::NUM_ROUNDS];

    logic [ice_pkg::RND_W-1:0]      last;
    logic [ice_pkg::RND_W-1:0]      sk_idx;
    logic                           sk_we;
    ice_pkg::sk_t                   sk_wdata;
    logic [31:0]                    f_out;

    // last round or subkey index for the mode
    assign last = thin_reg ? ice_pkg::RND_W'(ice_pkg::NUM_ROUNDS/2 - 1)
                           : ice_pkg::RND_W'(ice_pkg::NUM_ROUNDS - 1);

    // subkey order runs backward for decrypt
    assign sk_idx = kind_reg ? (last - rnd_reg) : rnd_reg;

    // shared round unit
    assign f_out = ice_pkg::round_fn(r_reg, sk_reg[sk_idx]);

    // subkey under construction
    assign sk_wdata = ice_pkg::sched_words(kb_reg, ice_pkg::ROT_TAB[cnt_reg]);

    // sequencer: schedule build, idle, rounds
    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        thin_next  = thin_reg;
        cnt_next   = cnt_reg;
        kb_next    = kb_reg;
        rnd_next   = rnd_reg;
        kind_next  = kind_reg;
        l_next     = l_reg;
        r_next     = r_reg;
        done_next  = 1'b0;
        out_next   = out_reg;
        sk_we      = 1'b0;

        case (state_reg)
            ice_pkg::ST_INIT:
            begin
                kb_next    = key_reg;
                cnt_next   = '0;
                state_next = ice_pkg::ST_SCHED;
            end
            ice_pkg::ST_SCHED:
            begin
                sk_we    = 1'b1;
                kb_next  = ice_pkg::kb_advance(kb_reg);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == last)
                    state_next = ice_pkg::ST_IDLE;
            end
            ice_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    kind_next  = kind;
                    l_next     = in_block[63:32];
                    r_next     = in_block[31:0];
                    rnd_next   = '0;
                    state_next = ice_pkg::ST_RUN;
                end
            end
            ice_pkg::ST_RUN:
            begin
                l_next   = r_reg;
                r_next   = l_reg ^ f_out;
                rnd_next = rnd_reg + 1'b1;
                if (rnd_reg == last)
                begin
                    done_next  = 1'b1;
                    out_next   = {l_reg ^ f_out, r_reg};
                    state_next = ice_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ice_pkg::ST_INIT;
            end
        endcase

        // register writes restart the schedule build
        if (cfg_we)
        begin
            case (cfg_index)
                ice_pkg::REG_KEY:
                begin
                    key_next   = cfg_data;
                    state_next = ice_pkg::ST_INIT;
                end
                ice_pkg::REG_THIN:
                begin
                    thin_next  = cfg_data[0];
                    state_next = ice_pkg::ST_INIT;
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    // control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ice_pkg::ST_INIT;
            key_reg   <= '0;
            thin_reg  <= 1'b0;
            cnt_reg   <= '0;
            rnd_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            key_reg   <= key_next;
            thin_reg  <= thin_next;
            cnt_reg   <= cnt_next;
            rnd_reg   <= rnd_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        kb_reg   <= kb_next;
        kind_reg <= kind_next;
        l_reg    <= l_next;
        r_reg    <= r_next;
        out_reg  <= out_next;
    end

    // subkey store
    always_ff @(posedge clk)
    begin
        if (sk_we)
            sk_reg[cnt_reg] <= sk_wdata;
    end

    assign busy      = (state_reg != ice_pkg::ST_IDLE);
    assign done      = done_reg;
    assign out_block = out_reg;

    // a result only comes out of the round state
    a_done_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ice_pkg::ST_RUN))
        else $error("result strobe without rounds");

    // an accepted request makes the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !cfg_we) |=> busy)
        else $error("accepted request did not start rounds");

    // round counter stays within the mode's round count
    a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ice_pkg::ST_RUN) |-> (rnd_reg <= last))
        else $error("round counter overran");

    // schedule counter stays within the mode's subkey count
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ice_pkg::ST_SCHED) |-> (cnt_reg <= last))
        else $error("schedule counter overran");

    // a key write restarts the schedule build
    a_key_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == ice_pkg::REG_KEY) |=> (state_reg == ice_pkg::ST_INIT))
        else $error("key write did not restart schedule");

endmodule
